// ===== hw/rtl/hcb_pkg.sv =====
// Package for the homography canvas bounds block: shared constants, register
// indexes and the coefficient set type. No dependencies.
package hcb_pkg;

	// Default parameter values.
	localparam int DIM_BITS_DEF  = 12;
	localparam int FRAC_BITS_DEF = 16;

	// Coordinate range: truncated coordinates saturate to [-2^20, 2^20-1].
	localparam int Q_BITS  = 20;
	localparam int COORD_W = Q_BITS + 1;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_PAIR_0 = 3'd0,
		REG_COEF_PAIR_1 = 3'd1,
		REG_COEF_PAIR_2 = 3'd2,
		REG_COEF_PAIR_3 = 3'd3,
		REG_COEF_LAST   = 3'd4
	} reg_idx_t;

	// One signed fixed-point coefficient.
	typedef logic signed [31:0] coef_t;

	// The full 3x3 matrix.
	typedef struct packed {
		coef_t h00;
		coef_t h01;
		coef_t h02;
		coef_t h10;
		coef_t h11;
		coef_t h12;
		coef_t h20;
		coef_t h21;
		coef_t h22;
	} hmat_t;

endpackage

// ===== hw/rtl/hcb_front.sv =====
// Front end of the canvas bounds block: accepts request transfers and holds
// them in a two-entry queue for the engine. Depends on hcb_pkg.
module hcb_front #(
	parameter int DIM_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [DIM_BITS-1:0] image_width,
	input  logic [DIM_BITS-1:0] image_height,
	input  logic [DIM_BITS-1:0] base_width,
	input  logic [DIM_BITS-1:0] base_height,
	output logic                q_valid,
	input  logic                q_ready,
	output logic [4*DIM_BITS-1:0] q_item
);
	import hcb_pkg::*;

	localparam int ITEM_W = 4 * DIM_BITS;

	logic [ITEM_W-1:0] entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;
	logic              pop;

	assign in_ready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// Queue storage takes the request fields as one word.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= {base_height, base_width, image_height, image_width};
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== hw/rtl/hcb_div.sv =====
// Coordinate resolver: divides a numerator by the third component one
// quotient bit a cycle, or scales by 1.0 with a shift. Depends on hcb_pkg.
module hcb_div #(
	parameter int NUM_W     = 47,
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       div_en,
	input  logic signed [NUM_W-1:0]    num,
	input  logic signed [NUM_W-1:0]    den,
	output logic                       done,
	output logic signed [hcb_pkg::COORD_W-1:0] q
);
	import hcb_pkg::*;

	localparam int DW    = NUM_W + Q_BITS;
	localparam int CNT_W = $clog2(Q_BITS);
	localparam logic signed [NUM_W-1:0] ONE  = NUM_W'(1) << FRAC_BITS;
	localparam logic signed [NUM_W-1:0] CMAX = NUM_W'((1 << Q_BITS) - 1);
	localparam logic signed [NUM_W-1:0] CMIN = ~CMAX;
	localparam logic signed [COORD_W-1:0] QMAX = COORD_W'((1 << Q_BITS) - 1);
	localparam logic signed [COORD_W-1:0] QMIN = ~QMAX;

	logic signed [NUM_W-1:0]   adj;
	logic signed [NUM_W-1:0]   sh;
	logic signed [COORD_W-1:0] sh_q;
	logic [NUM_W-1:0]          mag;
	logic [DW-1:0]             lim;
	logic                      sat;
	logic [DW-1:0]             rem_q;
	logic [DW-1:0]             dsh_q;
	logic [Q_BITS-1:0]         quo_q;
	logic [Q_BITS-1:0]         quo_nxt;
	logic [DW-1:0]             rem_nxt;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      neg_q;
	logic                      done_q;
	logic signed [COORD_W-1:0] q_q;

	// Scale path: truncate toward zero by 1.0, then saturate.
	always_comb begin
		adj = num + (num[NUM_W-1] ? (ONE - NUM_W'(1)) : NUM_W'(0));
		sh  = adj >>> FRAC_BITS;
		if (sh < CMIN) begin
			sh_q = QMIN;
		end else if (sh > CMAX) begin
			sh_q = QMAX;
		end else begin
			sh_q = sh[COORD_W-1:0];
		end
	end

	// Magnitude and the early saturation test against den * 2^20.
	always_comb begin
		mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		lim = {den[NUM_W-1:0], {Q_BITS{1'b0}}};
		sat = {{Q_BITS{1'b0}}, mag} >= lim;
	end

	// One restoring step.
	always_comb begin
		if (rem_q >= dsh_q) begin
			rem_nxt = rem_q - dsh_q;
			quo_nxt = {quo_q[Q_BITS-2:0], 1'b1};
		end else begin
			rem_nxt = rem_q;
			quo_nxt = {quo_q[Q_BITS-2:0], 1'b0};
		end
	end

	// Working registers of the iteration.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {{Q_BITS{1'b0}}, mag};
			dsh_q <= DW'({den[NUM_W-1:0], {(Q_BITS-1){1'b0}}});
			quo_q <= '0;
			neg_q <= num[NUM_W-1];
			if (!div_en) begin
				q_q <= sh_q;
			end else if (sat) begin
				q_q <= num[NUM_W-1] ? QMIN : QMAX;
			end
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dsh_q <= dsh_q >> 1;
			quo_q <= quo_nxt;
			if (cnt_q == '0) begin
				q_q <= neg_q ? -$signed({1'b0, quo_nxt}) : $signed({1'b0, quo_nxt});
			end
		end
	end

	// Control: busy flag, step count and a held done level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			if (!div_en || sat) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= CNT_W'(Q_BITS - 1);
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule

// ===== hw/rtl/hcb_engine.sv =====
// Back end of the canvas bounds block: projects the four corners one at a
// time, tracks min and max and holds the result. Depends on hcb_pkg, hcb_div.
module hcb_engine #(
	parameter int DIM_BITS  = 12,
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hcb_pkg::hmat_t        hm,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  logic [4*DIM_BITS-1:0] q_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [20:0]    min_x,
	output logic [19:0]           max_x,
	output logic signed [20:0]    min_y,
	output logic [19:0]           max_y,
	output logic [20:0]           offset_x,
	output logic [20:0]           offset_y,
	output logic [20:0]           canvas_width,
	output logic [20:0]           canvas_height
);
	import hcb_pkg::*;

	localparam int PROD_W = 32 + DIM_BITS + 1;
	localparam int NUM_W  = PROD_W + 2;
	localparam logic signed [NUM_W-1:0] ONE = NUM_W'(1) << FRAC_BITS;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_MUL   = 6'b000010,
		S_SUM   = 6'b000100,
		S_START = 6'b001000,
		S_DIV   = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t state_q;
	logic [1:0] corner_q;
	logic [DIM_BITS-1:0] w_q, h_q, bw_q, bh_q;
	logic signed [DIM_BITS:0] cx, cy;
	logic signed [PROD_W-1:0] pxx_s1, pxy_s1, pyx_s1, pyy_s1, pwx_s1, pwy_s1;
	logic signed [NUM_W-1:0] nx_s2, ny_s2, nw_s2;
	logic signed [COORD_W-1:0] mnx_q, mxx_q, mny_q, mxy_q;
	logic signed [COORD_W-1:0] qx, qy;
	logic done_x, done_y;
	logic div_start;
	logic div_en;
	logic out_free;
	logic out_valid_q;
	logic [COORD_W-1:0] offx, offy, ext_x, ext_y, bw_ext, bh_ext;

	assign q_ready   = (state_q == S_IDLE);
	assign div_start = (state_q == S_START);
	assign div_en    = (nw_s2 >= ONE);
	assign out_free  = !out_valid_q || out_ready;
	assign cx = corner_q[1] ? $signed({1'b0, w_q}) : '0;
	assign cy = corner_q[0] ? $signed({1'b0, h_q}) : '0;

	hcb_div #(.NUM_W(NUM_W), .FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start), .div_en(div_en),
		.num(nx_s2), .den(nw_s2), .done(done_x), .q(qx)
	);

	hcb_div #(.NUM_W(NUM_W), .FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start), .div_en(div_en),
		.num(ny_s2), .den(nw_s2), .done(done_y), .q(qy)
	);

	// Products for the current corner, then the three sums.
	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			pxx_s1 <= PROD_W'(hm.h00 * cx);
			pxy_s1 <= PROD_W'(hm.h01 * cy);
			pyx_s1 <= PROD_W'(hm.h10 * cx);
			pyy_s1 <= PROD_W'(hm.h11 * cy);
			pwx_s1 <= PROD_W'(hm.h20 * cx);
			pwy_s1 <= PROD_W'(hm.h21 * cy);
		end
		if (state_q == S_SUM) begin
			nx_s2 <= NUM_W'(pxx_s1) + NUM_W'(pxy_s1) + NUM_W'(hm.h02);
			ny_s2 <= NUM_W'(pyx_s1) + NUM_W'(pyy_s1) + NUM_W'(hm.h12);
			nw_s2 <= NUM_W'(pwx_s1) + NUM_W'(pwy_s1) + NUM_W'(hm.h22);
		end
	end

	// Request fields captured from the queue.
	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			{bh_q, bw_q, h_q, w_q} <= q_item;
		end
	end

	// Final arithmetic from the tracked extremes.
	always_comb begin
		offx   = COORD_W'(-mnx_q);
		offy   = COORD_W'(-mny_q);
		bw_ext = COORD_W'(bw_q);
		bh_ext = COORD_W'(bh_q);
		ext_x  = (mxx_q[COORD_W-1:0] > bw_ext) ? mxx_q[COORD_W-1:0] : bw_ext;
		ext_y  = (mxy_q[COORD_W-1:0] > bh_ext) ? mxy_q[COORD_W-1:0] : bh_ext;
	end

	// Result register; it frees the engine while the result waits.
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			min_x         <= mnx_q;
			max_x         <= mxx_q[Q_BITS-1:0];
			min_y         <= mny_q;
			max_y         <= mxy_q[Q_BITS-1:0];
			offset_x      <= offx;
			offset_y      <= offy;
			canvas_width  <= offx + ext_x;
			canvas_height <= offy + ext_y;
		end
	end

	// Sequencer over the four corners, extremes and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			corner_q    <= 2'd0;
			out_valid_q <= 1'b0;
			mnx_q       <= '0;
			mxx_q       <= '0;
			mny_q       <= '0;
			mxy_q       <= '0;
		end else begin
			// A new result replaces the one leaving in the same cycle.
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						corner_q <= 2'd0;
						mnx_q    <= '0;
						mxx_q    <= '0;
						mny_q    <= '0;
						mxy_q    <= '0;
						state_q  <= S_MUL;
					end
				end
				S_MUL:   state_q <= S_SUM;
				S_SUM:   state_q <= S_START;
				S_START: state_q <= S_DIV;
				S_DIV: begin
					if (done_x && done_y) begin
						if (qx < mnx_q) mnx_q <= qx;
						if (qx > mxx_q) mxx_q <= qx;
						if (qy < mny_q) mny_q <= qy;
						if (qy > mxy_q) mxy_q <= qy;
						corner_q <= corner_q + 2'd1;
						state_q  <= (corner_q == 2'd3) ? S_FIN : S_MUL;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/homography_canvas_bounds.sv =====
// Homography canvas bounds: four corners through a configured 3x3 matrix.
// Each corner takes a multiply, a sum, a start state and a divider run of 20 steps
// before done; a corner with W < 1 or early saturation skips the divider steps.
// The engine works on one request at a time; a two-entry request queue
// and a result register keep both sides moving. Reset sets H to identity.
module homography_canvas_bounds #(
	parameter int DIM_BITS  = hcb_pkg::DIM_BITS_DEF,
	parameter int FRAC_BITS = hcb_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [hcb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hcb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [DIM_BITS-1:0] image_width,
	input  logic [DIM_BITS-1:0] image_height,
	input  logic [DIM_BITS-1:0] base_width,
	input  logic [DIM_BITS-1:0] base_height,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [20:0]  min_x,
	output logic [19:0]         max_x,
	output logic signed [20:0]  min_y,
	output logic [19:0]         max_y,
	output logic [20:0]         offset_x,
	output logic [20:0]         offset_y,
	output logic [20:0]         canvas_width,
	output logic [20:0]         canvas_height
);
	import hcb_pkg::*;

	localparam coef_t UNITY = 32'(1) << FRAC_BITS;
	localparam hmat_t HM_RESET = '{h00: UNITY, h11: UNITY, h22: UNITY, default: '0};

	hmat_t hm_q;
	logic q_valid;
	logic q_ready;
	logic [4*DIM_BITS-1:0] q_item;

	assign cfg_ready = 1'b1;

	// Coefficient registers, written by configuration transfers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hm_q <= HM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COEF_PAIR_0: {hm_q.h01, hm_q.h00} <= cfg_data;
				REG_COEF_PAIR_1: {hm_q.h10, hm_q.h02} <= cfg_data;
				REG_COEF_PAIR_2: {hm_q.h12, hm_q.h11} <= cfg_data;
				REG_COEF_PAIR_3: {hm_q.h21, hm_q.h20} <= cfg_data;
				REG_COEF_LAST:   hm_q.h22 <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	hcb_front #(.DIM_BITS(DIM_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.image_width(image_width), .image_height(image_height),
		.base_width(base_width), .base_height(base_height),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	hcb_engine #(.DIM_BITS(DIM_BITS), .FRAC_BITS(FRAC_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n), .hm(hm_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready),
		.min_x(min_x), .max_x(max_x), .min_y(min_y), .max_y(max_y),
		.offset_x(offset_x), .offset_y(offset_y),
		.canvas_width(canvas_width), .canvas_height(canvas_height)
	);

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for homography_canvas_bounds: directed table, then random
// corner sets under several matrices. Depends on hcb_pkg and the block itself.
module testbench;
	import hcb_pkg::*;

	localparam int ONE = 65536;
	// Register indexes that name no register.
	localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [11:0] image_width = '0, image_height = '0, base_width = '0, base_height = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [20:0] min_x, min_y;
	logic [19:0] max_x, max_y;
	logic [20:0] offset_x, offset_y, canvas_width, canvas_height;

	typedef struct packed {
		logic [20:0] mnx;
		logic [19:0] mxx;
		logic [20:0] mny;
		logic [19:0] mxy;
		logic [20:0] offx;
		logic [20:0] offy;
		logic [20:0] cw;
		logic [20:0] ch;
	} bounds_t;

	typedef struct {
		logic [11:0] w, h, bw, bh;
		bit known;
		bounds_t res;
	} dir_row_t;

	bounds_t bounds_q[$];
	logic [63:0] pair0 = 64'd65536, pair1 = 0, pair2 = 64'd65536, pair3 = 0;
	logic [31:0] last_coef = 32'd65536;
	int errors = 0;
	int send_idle = 14, recv_idle = 53;

	homography_canvas_bounds uut (.*);

	// Clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Truncated, saturated coordinate from a numerator and third component.
	function automatic longint resolve_coord(longint num, longint wv);
		longint q;
		q = (wv >= ONE) ? num / wv : num / ONE;
		if (q < -(64'sd1 <<< 20)) q = -(64'sd1 <<< 20);
		if (q > (64'sd1 <<< 20) - 1) q = (64'sd1 <<< 20) - 1;
		return q;
	endfunction

	// Canvas bounds for one request under the current matrix.
	function automatic bounds_t canvas_bounds(logic [11:0] w, h, bw, bh);
		longint c[9];
		longint mnx, mxx, mny, mxy, cx, cy, px, py, nw, cw, ch, ox, oy;
		bounds_t r;
		c[0] = $signed(pair0[31:0]); c[1] = $signed(pair0[63:32]);
		c[2] = $signed(pair1[31:0]); c[3] = $signed(pair1[63:32]);
		c[4] = $signed(pair2[31:0]); c[5] = $signed(pair2[63:32]);
		c[6] = $signed(pair3[31:0]); c[7] = $signed(pair3[63:32]);
		c[8] = $signed(last_coef);
		mnx = 0; mxx = 0; mny = 0; mxy = 0;
		for (int k = 0; k < 4; k++) begin
			cx = (k & 2) ? longint'(w) : 0;
			cy = (k & 1) ? longint'(h) : 0;
			nw = c[6] * cx + c[7] * cy + c[8];
			px = resolve_coord(c[0] * cx + c[1] * cy + c[2], nw);
			py = resolve_coord(c[3] * cx + c[4] * cy + c[5], nw);
			if (px < mnx) mnx = px;
			if (px > mxx) mxx = px;
			if (py < mny) mny = py;
			if (py > mxy) mxy = py;
		end
		ox = -mnx;
		oy = -mny;
		cw = ox + ((mxx > longint'(bw)) ? mxx : longint'(bw));
		ch = oy + ((mxy > longint'(bh)) ? mxy : longint'(bh));
		r.mnx = mnx[20:0]; r.mxx = mxx[19:0]; r.mny = mny[20:0]; r.mxy = mxy[19:0];
		r.offx = ox[20:0]; r.offy = oy[20:0]; r.cw = cw[20:0]; r.ch = ch[20:0];
		return r;
	endfunction

	// Register write over the configuration channel; mirrors the bench copy.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_COEF_PAIR_0: pair0 = val;
			REG_COEF_PAIR_1: pair1 = val;
			REG_COEF_PAIR_2: pair2 = val;
			REG_COEF_PAIR_3: pair3 = val;
			REG_COEF_LAST:   last_coef = val[31:0];
			default: ;
		endcase
	endtask

	task automatic load_matrix(logic [63:0] p0, p1, p2, p3, logic [63:0] lst);
		write_reg(REG_COEF_PAIR_0, p0);
		write_reg(REG_COEF_PAIR_1, p1);
		write_reg(REG_COEF_PAIR_2, p2);
		write_reg(REG_COEF_PAIR_3, p3);
		write_reg(REG_COEF_LAST, lst);
	endtask

	// One request transfer, with random idle cycles before it. Valid stays up
	// after the transfer so that requests can follow back to back.
	task automatic send_request(logic [11:0] w, h, bw, bh, bit known, bounds_t res);
		bounds_t exp_r;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		image_width <= w; image_height <= h; base_width <= bw; base_height <= bh;
		exp_r = known ? res : canvas_bounds(w, h, bw, bh);
		bounds_q = {bounds_q, exp_r};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (bounds_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	// Random Q16.16 coefficient: mostly modest, sometimes anything.
	function automatic logic [31:0] rand_coef(int scale);
		if ($urandom_range(9) == 0) return $urandom;
		return $signed($urandom_range(2 * scale)) - scale;
	endfunction

	// Random matrix, usually near an affine or mild perspective warp.
	task automatic random_matrix();
		logic [31:0] a, b, c, d, e, f, g, k, m;
		a = ONE + rand_coef(40000); b = rand_coef(30000); c = rand_coef(32'h4000000);
		d = rand_coef(30000); e = ONE + rand_coef(40000); f = rand_coef(32'h4000000);
		g = $urandom_range(3) == 0 ? 32'(rand_coef(60)) : 32'd0;
		k = $urandom_range(3) == 0 ? 32'(rand_coef(60)) : 32'd0;
		m = $urandom_range(4) == 0 ? rand_coef(ONE * 2) : ONE;
		load_matrix({b, a}, {d, c}, {f, e}, {k, g}, {$urandom, m});
	endtask

	// Result side: random stalls and the check against the oldest expectation.
	always @(posedge clk) begin
		bounds_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (bounds_q.size() == 0) begin
					$error("result transfer with no expectation");
					errors++;
				end else begin
					e = bounds_q.pop_front();
					if (min_x !== e.mnx) begin
						$error("min_x expected %0d got %0d", $signed(e.mnx), min_x); errors++;
					end
					if (max_x !== e.mxx) begin
						$error("max_x expected %0d got %0d", e.mxx, max_x); errors++;
					end
					if (min_y !== e.mny) begin
						$error("min_y expected %0d got %0d", $signed(e.mny), min_y); errors++;
					end
					if (max_y !== e.mxy) begin
						$error("max_y expected %0d got %0d", e.mxy, max_y); errors++;
					end
					if (offset_x !== e.offx) begin
						$error("offset_x expected %0d got %0d", e.offx, offset_x); errors++;
					end
					if (offset_y !== e.offy) begin
						$error("offset_y expected %0d got %0d", e.offy, offset_y); errors++;
					end
					if (canvas_width !== e.cw) begin
						$error("canvas_width expected %0d got %0d", e.cw, canvas_width);
						errors++;
					end
					if (canvas_height !== e.ch) begin
						$error("canvas_height expected %0d got %0d", e.ch, canvas_height);
						errors++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Directed table, then random phases.
	initial begin
		dir_row_t rows[4];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity after reset: the extremes are just the image size, the canvas at least the base size.
		rows[0] = '{0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0, 0, 0}};
		rows[1] = '{4095, 4095, 0, 0, 1, '{0, 4095, 0, 4095, 0, 0, 4095, 4095}};
		rows[2] = '{100, 50, 4095, 4095, 1, '{0, 100, 0, 50, 0, 0, 4095, 4095}};
		rows[3] = '{12'hAAA, 12'h555, 12'h555, 12'hAAA, 1,
			'{0, 12'hAAA, 0, 12'h555, 0, 0, 12'hAAA, 12'hAAA}};
		foreach (rows[i]) send_request(rows[i].w, rows[i].h, rows[i].bw, rows[i].bh,
			rows[i].known, rows[i].res);
		drain();

		// Negative scale, zero and negative W, saturation, index above four.
		write_reg(REG_NONE_HI, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_NONE_LO, 64'h1234);
		load_matrix({32'h0, 32'hFFFF0000}, {32'h0, 32'h0}, {32'h0, 32'hFFFF0000}, 64'h0,
			64'hFFFF_FFFF_0001_0000);
		send_request(4095, 4095, 4095, 4095, 0, '0);
		send_request(1, 1, 0, 0, 0, '0);
		drain();
		load_matrix({32'h7FFFFFFF, 32'h7FFFFFFF}, {32'h7FFFFFFF, 32'h80000000},
			{32'h80000000, 32'h80000000}, 64'h0, 64'h0);
		send_request(4095, 4095, 4095, 4095, 0, '0);
		send_request(0, 0, 0, 0, 0, '0);
		drain();
		load_matrix({32'h0, 32'h10000}, 64'h0, {32'h0, 32'h10000}, {32'h0, 32'hFFFFFFFF},
			64'h8000_0000);
		send_request(4095, 4095, 1, 1, 0, '0);
		send_request(4095, 0, 0, 4095, 0, '0);
		drain();
		load_matrix({32'h0, 32'h20000}, {32'h0, 32'h0}, {32'h0, 32'h30000},
			{32'h10, 32'h20}, 64'h1_0000);
		send_request(4095, 4095, 0, 0, 0, '0);
		send_request(123, 4000, 2000, 17, 0, '0);
		drain();

		// Random phases with the three idle profiles.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 14 : (phase == 1) ? 53 : 0;
			recv_idle = (phase == 0) ? 53 : (phase == 1) ? 14 : 0;
			for (int blk = 0; blk < 11; blk++) begin
				random_matrix();
				for (int n = 0; n < 50; n++) begin
					send_request(12'($urandom), 12'($urandom), 12'($urandom),
						12'($urandom), 0, '0);
				end
				drain();
			end
		end

		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Timeout.
	initial begin
		#30ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
